/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition that must never be seen on a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)

`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

/* rtl/core/cvl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cvl_pkg;

	localparam int CAP     = 8;
	localparam int COUNT_W = 4;
	localparam int DATA_W  = 32;

	typedef enum logic [1:0] {
		ACT_ADD  = 2'd0,
		ACT_DEL  = 2'd1,
		ACT_DUMP = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// per-cell control from the list controller
	typedef struct packed {
		logic occupied;
		logic load;
		logic del_en;
		logic rot_en;
		logic rot_wrap;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/cvl_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module cvl_cell import cvl_pkg::*; (
	input  logic                     clk,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic signed [DATA_W-1:0] nxt_data,
	input  logic signed [DATA_W-1:0] head_data,
	input  logic                     hit_in,
	output logic                     hit_out,
	output logic signed [DATA_W-1:0] data
);

	logic signed [DATA_W-1:0] data_q;

	// a match here or in any earlier cell makes this cell take the next cell's value on a delete
	assign hit_out = hit_in || (ctl.occupied && (data_q == item_value));
	assign data    = data_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= item_value;
		end else if (ctl.del_en && ctl.occupied && hit_out) begin
			data_q <= nxt_data;
		end else if (ctl.rot_en && ctl.occupied) begin
			data_q <= ctl.rot_wrap ? head_data : nxt_data;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/compacting_value_list.sv */
// channel  | signals                                   | handshake
// ---------+-------------------------------------------+-------------------------
// command  | action, item_value                        | start high, busy low
// result   | status, entry_value, entry_count, last    | strobe, one cycle, no stall
//
// the result word of an add or delete shows the cycle after start
// a dump of n entries puts out one word a cycle, by rotating the cell chain
// busy is high after a dump is taken, while words one to n-1 are out
// reset clears the count and the result strobe; cell contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module compacting_value_list import cvl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [1:0]               action,
	input  logic signed [DATA_W-1:0] item_value,
	output logic                     busy,
	output logic                     strobe,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] entry_value,
	output logic [COUNT_W-1:0]       entry_count,
	output logic                     last
);

	logic [COUNT_W-1:0]       len_q;
	logic [COUNT_W-1:0]       cnt_q;
	logic                     dump_q;
	logic                     strobe_q;
	status_t                  status_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     last_q;

	logic                     acc;
	logic                     add_ok;
	logic                     del_en;
	logic                     dump_go;
	logic                     rot_en;
	logic                     found;
	logic                     is_last;
	logic [COUNT_W-1:0]       pos;
	action_t                  act;

	cell_ctl_t                ctl  [CAP];
	logic signed [DATA_W-1:0] data [CAP];
	logic                     hit  [CAP+1];

	assign act     = action_t'(action);
	assign acc     = start && !dump_q;
	assign add_ok  = acc && (act == ACT_ADD) && (len_q < COUNT_W'(CAP));
	assign del_en  = acc && (act == ACT_DEL);
	assign dump_go = acc && (act == ACT_DUMP) && (len_q != '0);
	assign rot_en  = dump_go || dump_q;
	assign found   = hit[CAP];
	assign pos     = dump_q ? cnt_q : '0;
	assign is_last = (pos + COUNT_W'(1)) == len_q;

	assign hit[0] = 1'b0;

	for (genvar i = 0; i < CAP; i++) begin : g_cell
		assign ctl[i].occupied = COUNT_W'(i) < len_q;
		assign ctl[i].load     = add_ok && (len_q == COUNT_W'(i));
		assign ctl[i].del_en   = del_en;
		assign ctl[i].rot_en   = rot_en;
		assign ctl[i].rot_wrap = (COUNT_W'(i) + COUNT_W'(1)) == len_q;

		cvl_cell u_cell (
			.clk        (clk),
			.ctl        (ctl[i]),
			.item_value (item_value),
			.nxt_data   ((i == CAP - 1) ? data[i] : data[(i + 1) % CAP]),
			.head_data  (data[0]),
			.hit_in     (hit[i]),
			.hit_out    (hit[i+1]),
			.data       (data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			cnt_q    <= '0;
			dump_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= rot_en || acc;
			if (add_ok) begin
				len_q <= len_q + COUNT_W'(1);
			end else if (del_en && found) begin
				len_q <= len_q - COUNT_W'(1);
			end
			if (rot_en) begin
				cnt_q  <= pos + COUNT_W'(1);
				dump_q <= !is_last;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (rot_en) begin
			status_q <= ST_OK;
			value_q  <= data[0];
			last_q   <= is_last;
		end else if (acc) begin
			value_q <= '0;
			last_q  <= 1'b1;
			unique case (act)
				ACT_ADD:  status_q <= add_ok ? ST_OK : ST_FULL;
				ACT_DEL:  status_q <= (len_q == '0) ? ST_EMPTY :
				                      (found ? ST_OK : ST_NOTFOUND);
				ACT_DUMP: status_q <= ST_EMPTY;
				default:  status_q <= ST_OK;
			endcase
		end
	end

	assign busy        = dump_q;
	assign strobe      = strobe_q;
	assign status      = status_q;
	assign entry_value = value_q;
	assign entry_count = len_q;
	assign last        = last_q;

	`ASSERT_CLK(a_len_range, len_q <= COUNT_W'(CAP), "count beyond capacity")
	`ASSERT_NEVER(a_dump_empty, dump_q && (len_q == '0), "dump running on empty list")
	`ASSERT_CLK(a_dump_word, dump_q |=> strobe_q, "dump cycle without result word")
	`ASSERT_CLK(a_dump_end, (dump_q && is_last) |=> (strobe_q && last_q && !dump_q), "dump end lost")
	`ASSERT_CLK(a_len_hold, dump_q |=> $stable(len_q), "count changed during dump")

endmodule

`default_nettype wire

/* verif/compacting_value_list_tb.sv */
`timescale 1ns / 1ps

module compacting_value_list_tb;

	import cvl_pkg::*;

	localparam int RANDOM_CMDS  = 400;
	localparam int SETTLE_LIMIT = 400;
	localparam int TAIL_CYCLES  = 2 * CAP + 4;

	typedef struct packed {
		action_t           act;
		logic [DATA_W-1:0] val;
		logic [7:0]        gap;
		logic              drain;
	} list_cmd_t;

	typedef struct packed {
		status_t            st;
		logic [DATA_W-1:0]  val;
		logic [COUNT_W-1:0] count;
		logic               last;
	} list_word_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [1:0]               action = ACT_ADD;
	logic signed [DATA_W-1:0] item_value = '0;
	logic                     busy;
	logic                     strobe;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] entry_value;
	logic [COUNT_W-1:0]       entry_count;
	logic                     last;

	list_cmd_t  cmd_backlog[$];
	list_word_t due_words[$];
	list_cmd_t  next_cmd;
	list_word_t want;
	logic       cmd_accepted = 1'b0;
	logic [7:0] idle_left = '0;
	int         mismatch_count = 0;
	bit         burst = 1'b0;

	// shadow of the list contents
	logic [DATA_W-1:0] list_vals[CAP];
	int                list_len = 0;

	compacting_value_list dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.item_value  (item_value),
		.busy        (busy),
		.strobe      (strobe),
		.status      (status),
		.entry_value (entry_value),
		.entry_count (entry_count),
		.last        (last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("compacting_value_list_tb: FAIL");
		$finish;
	end

	task automatic push_word(input status_t st, input logic [DATA_W-1:0] val,
			input logic last_flag);
		list_word_t w;
		w.st    = st;
		w.val   = val;
		w.count = list_len[COUNT_W-1:0];
		w.last  = last_flag;
		due_words.push_back(w);
	endtask

	task automatic predict_list_op(input action_t act, input logic [DATA_W-1:0] val);
		int i;
		int hit_at;
		hit_at = -1;
		case (act)
			ACT_ADD: begin
				if (list_len >= CAP) begin
					push_word(ST_FULL, '0, 1'b1);
				end else begin
					list_vals[list_len] = val;
					list_len++;
					push_word(ST_OK, '0, 1'b1);
				end
			end
			ACT_DEL: begin
				if (list_len == 0) begin
					push_word(ST_EMPTY, '0, 1'b1);
				end else begin
					for (i = 0; i < list_len; i++)
						if (hit_at < 0 && list_vals[i] == val)
							hit_at = i;
					if (hit_at < 0) begin
						push_word(ST_NOTFOUND, '0, 1'b1);
					end else begin
						// close the gap left by the removed entry
						for (i = hit_at; i + 1 < list_len; i++)
							list_vals[i] = list_vals[i + 1];
						list_len--;
						push_word(ST_OK, '0, 1'b1);
					end
				end
			end
			ACT_DUMP: begin
				if (list_len == 0) begin
					push_word(ST_EMPTY, '0, 1'b1);
				end else begin
					for (i = 0; i < list_len; i++)
						push_word(ST_OK, list_vals[i], i + 1 == list_len);
				end
			end
			default: begin
				push_word(ST_OK, '0, 1'b1);
			end
		endcase
	endtask

	function automatic logic [7:0] pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (burst || roll < 55)
			return 8'd0;
		if (roll < 90)
			return 8'($urandom_range(1, 3));
		return 8'($urandom_range(8, 40));
	endfunction

	task automatic queue_cmd(input action_t act, input logic [DATA_W-1:0] val,
			input logic drain);
		list_cmd_t c;
		c.act   = act;
		c.val   = val;
		c.gap   = pick_gap();
		c.drain = drain;
		cmd_backlog.push_back(c);
	endtask

	// driver: new word at the falling edge once the previous one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !cmd_accepted) begin
			// hold the word while busy
		end else if (idle_left != 0) begin
			start <= 1'b0;
			idle_left <= idle_left - 8'd1;
		end else if (cmd_backlog.size() != 0 &&
				!(cmd_backlog[0].drain && due_words.size() != 0)) begin
			next_cmd = cmd_backlog.pop_front();
			start <= 1'b1;
			action <= next_cmd.act;
			item_value <= next_cmd.val;
			idle_left <= next_cmd.gap;
		end else begin
			start <= 1'b0;
		end
	end

	// monitor: check result words, then record the accepted command
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_accepted <= 1'b0;
		end else begin
			if (strobe) begin
				if (due_words.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected word: status %0d value %h count %0d last %b",
							$time, status, entry_value, entry_count, last);
				end else begin
					want = due_words.pop_front();
					if (status !== want.st || entry_value !== want.val ||
							entry_count !== want.count || last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: expected status %0d value %h count %0d last %b, got status %0d value %h count %0d last %b",
								$time, want.st, want.val, want.count, want.last,
								status, entry_value, entry_count, last);
					end
				end
			end
			cmd_accepted <= start && !busy;
			if (start && !busy)
				predict_list_op(action_t'(action), item_value);
		end
	end

	initial begin
		logic [DATA_W-1:0] pool[6];
		logic [DATA_W-1:0] val;
		bit                filling;
		int                n;
		int                roll;
		int                settle;
		action_t           act;

		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7FFF_FFFF;
		pool[2] = 32'h0000_0000;
		pool[3] = 32'hFFFF_FFFF;
		pool[4] = 32'd5;
		pool[5] = 32'h1234_5678;

		// empty-list corner cases
		queue_cmd(ACT_DUMP, 32'hDEAD_BEEF, 1'b0);
		queue_cmd(ACT_DEL, 32'd5, 1'b0);
		queue_cmd(ACT_NONE, 32'hFFFF_FFFF, 1'b0);
		// fill to capacity with extremes and duplicates, then add one past it
		queue_cmd(ACT_ADD, 32'h8000_0000, 1'b0);
		queue_cmd(ACT_ADD, 32'h7FFF_FFFF, 1'b0);
		queue_cmd(ACT_ADD, 32'h0000_0000, 1'b0);
		queue_cmd(ACT_ADD, 32'hFFFF_FFFF, 1'b0);
		queue_cmd(ACT_ADD, 32'd5, 1'b0);
		queue_cmd(ACT_ADD, 32'd5, 1'b0);
		queue_cmd(ACT_ADD, 32'd1, 1'b0);
		queue_cmd(ACT_ADD, 32'h8000_0000, 1'b0);
		queue_cmd(ACT_ADD, 32'd12, 1'b0);
		queue_cmd(ACT_DUMP, 32'h0, 1'b1);
		queue_cmd(ACT_NONE, 32'h0, 1'b0);
		// first match only, then a miss, then head and tail removal
		queue_cmd(ACT_DEL, 32'd5, 1'b0);
		queue_cmd(ACT_DEL, 32'd42, 1'b0);
		queue_cmd(ACT_DEL, 32'h8000_0000, 1'b0);
		queue_cmd(ACT_DEL, 32'h8000_0000, 1'b0);
		queue_cmd(ACT_DEL, 32'd1, 1'b0);
		queue_cmd(ACT_DUMP, 32'hFFFF_FFFF, 1'b0);

		filling = 1'b0;
		for (n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 40 == 0) begin
				filling = !filling;
				burst = ($urandom_range(0, 3) == 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 4)
				act = ACT_NONE;
			else if (roll < 15)
				act = ACT_DUMP;
			else if (roll < 15 + (filling ? 65 : 20))
				act = ACT_ADD;
			else
				act = ACT_DEL;
			val = ($urandom_range(0, 3) == 0) ? $urandom() : pool[$urandom_range(0, 5)];
			queue_cmd(act, val, n % 97 == 50);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		settle = 0;
		while ((cmd_backlog.size() != 0 || start || due_words.size() != 0) &&
				settle < SETTLE_LIMIT) begin
			@(negedge clk);
			if (cmd_backlog.size() == 0 && !start)
				settle++;
		end
		repeat (TAIL_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && due_words.size() == 0)
			$display("compacting_value_list_tb: PASS");
		else
			$display("compacting_value_list_tb: FAIL");
		$finish;
	end

endmodule
